// ===== rtl/c8_pkg.sv =====
// Shared types, constants and codes of the CHIP-8 instruction core.
package c8_pkg;

  localparam int PROGRAM_START  = 512;
  localparam int DISPLAY_PIXELS = 2048;
  localparam int STACK_DEPTH    = 16;

  localparam int AW        = 12;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int SCREEN_W  = 64;
  localparam int ROWS      = DISPLAY_PIXELS / SCREEN_W;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int SPW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W     = 5;
  localparam int FONT_LEN  = 80;

  // item commands
  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_PIXEL = 2'd3;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_SYS   = 2'd2;
  localparam logic [1:0] ST_HALT  = 2'd3;

  // opcode groups (top nibble)
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEK  = 4'h3;
  localparam logic [3:0] OPC_SNEK = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LDK  = 4'h6;
  localparam logic [3:0] OPC_ADDK = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_JPV0 = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // ALU sub-ops of group 8
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;

  // group F low bytes
  localparam logic [7:0] FX_GET_DT = 8'h07;
  localparam logic [7:0] FX_WAIT   = 8'h0A;
  localparam logic [7:0] FX_SET_DT = 8'h15;
  localparam logic [7:0] FX_SET_ST = 8'h18;
  localparam logic [7:0] FX_ADD_I  = 8'h1E;
  localparam logic [7:0] FX_FONT   = 8'h29;
  localparam logic [7:0] FX_BCD    = 8'h33;
  localparam logic [7:0] FX_STORE  = 8'h55;
  localparam logic [7:0] FX_LOAD   = 8'h65;

  localparam logic [3:0] FLAG_REG = 4'hF;

  // sequencer steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_CLEAR = 5'd0;
  localparam logic [STEP_W-1:0] S_IDLE  = 5'd1;
  localparam logic [STEP_W-1:0] S_CMD   = 5'd2;
  localparam logic [STEP_W-1:0] S_RDM   = 5'd3;
  localparam logic [STEP_W-1:0] S_RDP   = 5'd4;
  localparam logic [STEP_W-1:0] S_F1    = 5'd5;
  localparam logic [STEP_W-1:0] S_F2    = 5'd6;
  localparam logic [STEP_W-1:0] S_F3    = 5'd7;
  localparam logic [STEP_W-1:0] S_F4    = 5'd8;
  localparam logic [STEP_W-1:0] S_EX    = 5'd9;
  localparam logic [STEP_W-1:0] S_FLAG  = 5'd10;
  localparam logic [STEP_W-1:0] S_CLS   = 5'd11;
  localparam logic [STEP_W-1:0] S_DR0   = 5'd12;
  localparam logic [STEP_W-1:0] S_DR1   = 5'd13;
  localparam logic [STEP_W-1:0] S_DR2   = 5'd14;
  localparam logic [STEP_W-1:0] S_DRF   = 5'd15;
  localparam logic [STEP_W-1:0] S_BCD   = 5'd16;
  localparam logic [STEP_W-1:0] S_ST0   = 5'd17;
  localparam logic [STEP_W-1:0] S_ST1   = 5'd18;
  localparam logic [STEP_W-1:0] S_LD0   = 5'd19;
  localparam logic [STEP_W-1:0] S_LD1   = 5'd20;
  localparam logic [STEP_W-1:0] S_FIN   = 5'd21;
  localparam logic [STEP_W-1:0] S_DONE  = 5'd22;

  // instruction kinds seen by the controller
  localparam logic [3:0] K_SIMPLE  = 4'd0;
  localparam logic [3:0] K_FLAG    = 4'd1;
  localparam logic [3:0] K_CLS     = 4'd2;
  localparam logic [3:0] K_DRAW    = 4'd3;
  localparam logic [3:0] K_DRAW0   = 4'd4;
  localparam logic [3:0] K_BCD     = 4'd5;
  localparam logic [3:0] K_STORE   = 4'd6;
  localparam logic [3:0] K_LOAD    = 4'd7;
  localparam logic [3:0] K_ILLEGAL = 4'd8;
  localparam logic [3:0] K_NOKEY   = 4'd9;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] keypad;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] program_counter;
    logic [7:0]  read_data;
    logic        display_changed;
    logic        sound_active;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              accept;
  } ctl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       halted;
    logic [3:0] kind;
    logic       last;
    logic       out_free;
  } sts_t;

  localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

// ===== rtl/c8_ram.sv =====
// Generic simple dual-port RAM with registered read.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/c8_ctrl.sv =====
// Sequencer state machine of the CHIP-8 core.
module c8_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  c8_pkg::sts_t sts,
  output c8_pkg::ctl_t ctl
);

  logic [c8_pkg::STEP_W-1:0] state;
  logic [c8_pkg::STEP_W-1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      c8_pkg::S_CLEAR: if (sts.last) state_next = c8_pkg::S_IDLE;
      c8_pkg::S_IDLE:  if (item_valid) state_next = c8_pkg::S_CMD;
      c8_pkg::S_CMD: begin
        case (sts.command)
          c8_pkg::CMD_WRITE: state_next = c8_pkg::S_DONE;
          c8_pkg::CMD_READ:  state_next = c8_pkg::S_RDM;
          c8_pkg::CMD_PIXEL: state_next = c8_pkg::S_RDP;
          default:           state_next = sts.halted ? c8_pkg::S_DONE : c8_pkg::S_F1;
        endcase
      end
      c8_pkg::S_RDM: state_next = c8_pkg::S_DONE;
      c8_pkg::S_RDP: state_next = c8_pkg::S_DONE;
      c8_pkg::S_F1:  state_next = c8_pkg::S_F2;
      c8_pkg::S_F2:  state_next = c8_pkg::S_F3;
      c8_pkg::S_F3:  state_next = c8_pkg::S_F4;
      c8_pkg::S_F4:  state_next = c8_pkg::S_EX;
      c8_pkg::S_EX: begin
        case (sts.kind)
          c8_pkg::K_FLAG:    state_next = c8_pkg::S_FLAG;
          c8_pkg::K_CLS:     state_next = c8_pkg::S_CLS;
          c8_pkg::K_DRAW:    state_next = c8_pkg::S_DR0;
          c8_pkg::K_DRAW0:   state_next = c8_pkg::S_DRF;
          c8_pkg::K_BCD:     state_next = c8_pkg::S_BCD;
          c8_pkg::K_STORE:   state_next = c8_pkg::S_ST0;
          c8_pkg::K_LOAD:    state_next = c8_pkg::S_LD0;
          c8_pkg::K_ILLEGAL: state_next = c8_pkg::S_DONE;
          c8_pkg::K_NOKEY:   state_next = c8_pkg::S_DONE;
          default:           state_next = c8_pkg::S_FIN;
        endcase
      end
      c8_pkg::S_FLAG: state_next = c8_pkg::S_FIN;
      c8_pkg::S_CLS:  if (sts.last) state_next = c8_pkg::S_FIN;
      c8_pkg::S_DR0:  state_next = c8_pkg::S_DR1;
      c8_pkg::S_DR1:  state_next = c8_pkg::S_DR2;
      c8_pkg::S_DR2:  state_next = sts.last ? c8_pkg::S_DRF : c8_pkg::S_DR0;
      c8_pkg::S_DRF:  state_next = c8_pkg::S_FIN;
      c8_pkg::S_BCD:  if (sts.last) state_next = c8_pkg::S_FIN;
      c8_pkg::S_ST0:  state_next = c8_pkg::S_ST1;
      c8_pkg::S_ST1:  state_next = sts.last ? c8_pkg::S_FIN : c8_pkg::S_ST0;
      c8_pkg::S_LD0:  state_next = c8_pkg::S_LD1;
      c8_pkg::S_LD1:  state_next = sts.last ? c8_pkg::S_FIN : c8_pkg::S_LD0;
      c8_pkg::S_FIN:  state_next = c8_pkg::S_DONE;
      c8_pkg::S_DONE: if (sts.out_free) state_next = c8_pkg::S_IDLE;
      default:        state_next = c8_pkg::S_IDLE;
    endcase
  end

  assign ctl.step   = state;
  assign ctl.accept = (state == c8_pkg::S_IDLE) && item_valid;

endmodule

// ===== rtl/c8_datapath.sv =====
// Datapath of the CHIP-8 core: registers, memories, ALU and result register.
module c8_datapath (
  input  logic              clk,
  input  logic              rst,
  input  c8_pkg::in_item_t  item,
  input  c8_pkg::ctl_t      ctl,
  output c8_pkg::sts_t      sts,
  output logic              result_valid,
  input  logic              result_stall,
  output c8_pkg::out_item_t result
);

  localparam int AW     = c8_pkg::AW;
  localparam int SPW    = c8_pkg::SPW;
  localparam int ROW_AW = c8_pkg::ROW_AW;
  localparam int CNT_W  = c8_pkg::CNT_W;

  // architectural and control state
  logic [AW-1:0]    pc;
  logic [AW-1:0]    idx;
  logic [SPW-1:0]   sp;
  logic [7:0]       dt;
  logic [7:0]       st;
  logic             halted;
  logic [AW-1:0]    clr;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    stack [c8_pkg::STACK_DEPTH];

  // per-item working registers
  c8_pkg::in_item_t it;
  logic [15:0]      ir;
  logic [7:0]       vx;
  logic [7:0]       vy;
  logic [AW-1:0]    nxt;
  logic [1:0]       stat;
  logic             drew;
  logic [7:0]       rdat;
  logic             flag;
  logic             hit;
  logic [7:0]       sbyte;

  // memory ports
  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_q;
  logic              f_we;
  logic [ROW_AW-1:0] f_waddr, f_raddr;
  logic [63:0]       f_wdata, f_q;
  logic       r_we;
  logic [3:0] r_waddr, r_raddr;
  logic [7:0] r_wdata, r_q;

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_DEPTH)) u_main (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_q)
  );

  c8_ram #(.WIDTH(c8_pkg::SCREEN_W), .DEPTH(c8_pkg::ROWS)) u_frame (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_q)
  );

  c8_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r_q)
  );

  // opcode fields
  logic [3:0]    op_hi, x, y, n;
  logic [7:0]    kk;
  logic [AW-1:0] nnn;
  assign op_hi = ir[15:12];
  assign x     = ir[11:8];
  assign y     = ir[7:4];
  assign n     = ir[3:0];
  assign kk    = ir[7:0];
  assign nnn   = ir[11:0];

  logic [SPW-1:0] sp_inc, sp_dec;
  assign sp_inc = (sp == SPW'(c8_pkg::STACK_DEPTH - 1)) ? '0 : sp + SPW'(1);
  assign sp_dec = (sp == '0) ? SPW'(c8_pkg::STACK_DEPTH - 1) : sp - SPW'(1);

  logic [AW-1:0] pc_p1, pc_p2, pc_p4, mem_ptr;
  assign pc_p1   = pc + AW'(1);
  assign pc_p2   = pc + AW'(2);
  assign pc_p4   = pc + AW'(4);
  assign mem_ptr = idx + AW'(cnt);

  // highest held key
  logic       any_key;
  logic [3:0] key_num;
  always_comb begin
    key_num = '0;
    for (int i = 0; i < 16; i++) begin
      if (it.keypad[i]) key_num = 4'(i);
    end
  end
  assign any_key = |it.keypad;

  logic key_held;
  assign key_held = it.keypad[vx[3:0]];

  // group 8 ALU
  logic [8:0] sum9;
  logic [7:0] alu_res;
  logic       alu_flag;
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  always_comb begin
    alu_res  = vy;
    alu_flag = 1'b0;
    case (n)
      c8_pkg::ALU_MOV: alu_res = vy;
      c8_pkg::ALU_OR:  alu_res = vx | vy;
      c8_pkg::ALU_AND: alu_res = vx & vy;
      c8_pkg::ALU_XOR: alu_res = vx ^ vy;
      c8_pkg::ALU_ADD: begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
      c8_pkg::ALU_SUB: begin alu_res = vx - vy; alu_flag = (vx >= vy); end
      c8_pkg::ALU_SHR: begin alu_res = {1'b0, vx[7:1]}; alu_flag = vx[0]; end
      c8_pkg::ALU_SBN: begin alu_res = vy - vx; alu_flag = (vy >= vx); end
      c8_pkg::ALU_SHL: begin alu_res = {vx[6:0], 1'b0}; alu_flag = vx[7]; end
      default: begin alu_res = vy; alu_flag = 1'b0; end
    endcase
  end

  // decimal digits of Vx
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tprod;
  logic [3:0]  tens, ones;
  logic [7:0]  digit;
  always_comb begin
    if (vx >= 8'd200) hund = 2'd2;
    else if (vx >= 8'd100) hund = 2'd1;
    else hund = 2'd0;
    rem   = 7'(vx - 8'(hund) * 8'd100);
    tprod = 15'(rem) * 15'd205;
    tens  = tprod[14:11];
    ones  = 4'(rem - 7'(tens) * 7'd10);
    case (cnt[1:0])
      2'd0:    digit = {6'b0, hund};
      2'd1:    digit = {4'b0, tens};
      default: digit = {4'b0, ones};
    endcase
  end

  // instruction kind
  logic [3:0] kind;
  always_comb begin
    kind = c8_pkg::K_SIMPLE;
    case (op_hi)
      c8_pkg::OPC_SYS: if (ir == c8_pkg::OP_CLS) kind = c8_pkg::K_CLS;
      c8_pkg::OPC_ALU: begin
        case (n)
          c8_pkg::ALU_MOV, c8_pkg::ALU_OR, c8_pkg::ALU_AND, c8_pkg::ALU_XOR:
            kind = c8_pkg::K_SIMPLE;
          c8_pkg::ALU_ADD, c8_pkg::ALU_SUB, c8_pkg::ALU_SHR, c8_pkg::ALU_SBN,
          c8_pkg::ALU_SHL:
            kind = c8_pkg::K_FLAG;
          default: kind = c8_pkg::K_ILLEGAL;
        endcase
      end
      c8_pkg::OPC_DRW: kind = (n == 4'd0) ? c8_pkg::K_DRAW0 : c8_pkg::K_DRAW;
      c8_pkg::OPC_MISC: begin
        case (kk)
          c8_pkg::FX_GET_DT, c8_pkg::FX_SET_DT, c8_pkg::FX_SET_ST,
          c8_pkg::FX_ADD_I, c8_pkg::FX_FONT:
            kind = c8_pkg::K_SIMPLE;
          c8_pkg::FX_WAIT:  kind = any_key ? c8_pkg::K_SIMPLE : c8_pkg::K_NOKEY;
          c8_pkg::FX_BCD:   kind = c8_pkg::K_BCD;
          c8_pkg::FX_STORE: kind = c8_pkg::K_STORE;
          c8_pkg::FX_LOAD:  kind = c8_pkg::K_LOAD;
          default:          kind = c8_pkg::K_ILLEGAL;
        endcase
      end
      default: kind = c8_pkg::K_SIMPLE;
    endcase
  end

  // Vx write-back from the execute step
  logic       ex_wr;
  logic [7:0] ex_val;
  always_comb begin
    ex_wr  = 1'b0;
    ex_val = kk;
    case (op_hi)
      c8_pkg::OPC_LDK:  begin ex_wr = 1'b1; ex_val = kk; end
      c8_pkg::OPC_ADDK: begin ex_wr = 1'b1; ex_val = vx + kk; end
      c8_pkg::OPC_ALU:  begin ex_wr = (kind != c8_pkg::K_ILLEGAL); ex_val = alu_res; end
      c8_pkg::OPC_RND:  begin ex_wr = 1'b1; ex_val = it.random_byte & kk; end
      c8_pkg::OPC_MISC: begin
        if (kk == c8_pkg::FX_GET_DT) begin
          ex_wr  = 1'b1;
          ex_val = dt;
        end else if (kk == c8_pkg::FX_WAIT) begin
          ex_wr  = any_key;
          ex_val = {4'b0, key_num};
        end
      end
      default: ex_wr = 1'b0;
    endcase
  end

  // program counter after the instruction in the execute step
  logic [AW-1:0] ex_next;
  always_comb begin
    ex_next = pc_p2;
    case (op_hi)
      c8_pkg::OPC_SYS:  if (ir == c8_pkg::OP_RET) ex_next = stack[sp_dec] + AW'(2);
      c8_pkg::OPC_JP, c8_pkg::OPC_CALL: ex_next = nnn;
      c8_pkg::OPC_SEK:  if (vx == kk) ex_next = pc_p4;
      c8_pkg::OPC_SNEK: if (vx != kk) ex_next = pc_p4;
      c8_pkg::OPC_SER:  if (vx == vy) ex_next = pc_p4;
      c8_pkg::OPC_SNER: if (vx != vy) ex_next = pc_p4;
      c8_pkg::OPC_JPV0: ex_next = nnn + AW'(vy);
      c8_pkg::OPC_KEY: begin
        if ((kk == c8_pkg::KEY_DOWN) ? key_held : !key_held) ex_next = pc_p4;
      end
      default: ex_next = pc_p2;
    endcase
  end

  // sprite row: pixel x sits at bit x of a frame row
  logic [ROW_AW-1:0] draw_row;
  logic [63:0]       base, mask;
  logic [127:0]      rot;
  assign draw_row = ROW_AW'(vy) + ROW_AW'(cnt);
  always_comb begin
    base = '0;
    for (int c = 0; c < 8; c++) begin
      base[c] = sbyte[7-c];
    end
  end
  assign rot  = {base, base} << vx[5:0];
  assign mask = rot[127:64];

  // memory port selection
  always_comb begin
    m_we    = 1'b0;
    m_waddr = mem_ptr;
    m_wdata = r_q;
    m_raddr = pc;
    f_we    = 1'b0;
    f_waddr = draw_row;
    f_wdata = f_q ^ mask;
    f_raddr = draw_row;
    r_we    = 1'b0;
    r_waddr = x;
    r_wdata = ex_val;
    r_raddr = x;
    case (ctl.step)
      c8_pkg::S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr;
        m_wdata = (clr < AW'(c8_pkg::FONT_LEN)) ? c8_pkg::FONT_ROM[clr[6:0]] : 8'd0;
        f_we    = (clr < AW'(c8_pkg::ROWS));
        f_waddr = clr[ROW_AW-1:0];
        f_wdata = '0;
        r_we    = (clr < AW'(16));
        r_waddr = clr[3:0];
        r_wdata = '0;
      end
      c8_pkg::S_CMD: begin
        m_we    = (it.command == c8_pkg::CMD_WRITE);
        m_waddr = it.address;
        m_wdata = it.write_data;
        m_raddr = (it.command == c8_pkg::CMD_EXEC) ? pc : it.address;
        f_raddr = it.address[ROW_AW+5:6];
      end
      c8_pkg::S_F1: m_raddr = pc_p1;
      c8_pkg::S_F2: r_raddr = x;
      c8_pkg::S_F3: r_raddr = (op_hi == c8_pkg::OPC_JPV0) ? 4'd0 : y;
      c8_pkg::S_EX: r_we = ex_wr;
      c8_pkg::S_FLAG: begin
        r_we    = 1'b1;
        r_waddr = c8_pkg::FLAG_REG;
        r_wdata = {7'b0, flag};
      end
      c8_pkg::S_CLS: begin
        f_we    = 1'b1;
        f_waddr = cnt[ROW_AW-1:0];
        f_wdata = '0;
      end
      c8_pkg::S_DR0: m_raddr = mem_ptr;
      c8_pkg::S_DR2: f_we = 1'b1;
      c8_pkg::S_DRF: begin
        r_we    = 1'b1;
        r_waddr = c8_pkg::FLAG_REG;
        r_wdata = {7'b0, hit};
      end
      c8_pkg::S_BCD: begin
        m_we    = 1'b1;
        m_wdata = digit;
      end
      c8_pkg::S_ST0: r_raddr = cnt[3:0];
      c8_pkg::S_ST1: m_we = 1'b1;
      c8_pkg::S_LD0: m_raddr = mem_ptr;
      c8_pkg::S_LD1: begin
        r_we    = 1'b1;
        r_waddr = cnt[3:0];
        r_wdata = m_q;
      end
      default: m_we = 1'b0;
    endcase
  end

  // loop end for the step in progress
  logic last;
  always_comb begin
    case (ctl.step)
      c8_pkg::S_CLEAR: last = (clr == AW'(c8_pkg::MEM_DEPTH - 1));
      c8_pkg::S_CLS:   last = (cnt == CNT_W'(c8_pkg::ROWS - 1));
      c8_pkg::S_DR2:   last = (cnt == CNT_W'(n) - CNT_W'(1));
      c8_pkg::S_BCD:   last = (cnt == CNT_W'(2));
      c8_pkg::S_ST1:   last = (cnt[3:0] == x);
      c8_pkg::S_LD1:   last = (cnt[3:0] == x);
      default:         last = 1'b0;
    endcase
  end

  logic out_free;
  assign out_free = !result_valid || !result_stall;

  assign sts.command  = it.command;
  assign sts.halted   = halted;
  assign sts.kind     = kind;
  assign sts.last     = last;
  assign sts.out_free = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= AW'(c8_pkg::PROGRAM_START);
      idx          <= '0;
      sp           <= '0;
      dt           <= '0;
      st           <= '0;
      halted       <= 1'b0;
      clr          <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < c8_pkg::STACK_DEPTH; i++) begin
        stack[i] <= '0;
      end
    end else begin
      if (ctl.step == c8_pkg::S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (ctl.step)
        c8_pkg::S_CLEAR: clr <= clr + AW'(1);
        c8_pkg::S_EX: begin
          cnt <= '0;
          case (op_hi)
            c8_pkg::OPC_SYS: if (ir == c8_pkg::OP_RET) sp <= sp_dec;
            c8_pkg::OPC_CALL: begin
              stack[sp] <= pc;
              sp        <= sp_inc;
            end
            c8_pkg::OPC_LDI: idx <= nnn;
            c8_pkg::OPC_MISC: begin
              case (kk)
                c8_pkg::FX_SET_DT: dt  <= vx;
                c8_pkg::FX_SET_ST: st  <= vx;
                c8_pkg::FX_ADD_I:  idx <= idx + AW'(vx);
                c8_pkg::FX_FONT:   idx <= AW'({vx[3:0], 2'b00}) + AW'(vx[3:0]);
                default:           idx <= idx;
              endcase
            end
            default: idx <= idx;
          endcase
          if (kind == c8_pkg::K_ILLEGAL) halted <= 1'b1;
        end
        c8_pkg::S_CLS, c8_pkg::S_DR2, c8_pkg::S_BCD, c8_pkg::S_ST1, c8_pkg::S_LD1:
          cnt <= cnt + CNT_W'(1);
        c8_pkg::S_FIN: begin
          pc <= nxt;
          if (dt != 8'd0) dt <= dt - 8'd1;
          if (st != 8'd0) st <= st - 8'd1;
        end
        default: cnt <= cnt;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      it   <= item;
      stat <= halted ? c8_pkg::ST_HALT : c8_pkg::ST_OK;
      drew <= 1'b0;
      rdat <= '0;
    end
    case (ctl.step)
      c8_pkg::S_RDM: rdat <= m_q;
      c8_pkg::S_RDP: rdat <= {7'b0, f_q[it.address[5:0]]};
      c8_pkg::S_F1:  ir[15:8] <= m_q;
      c8_pkg::S_F2:  ir[7:0] <= m_q;
      c8_pkg::S_F3:  vx <= r_q;
      c8_pkg::S_F4:  vy <= r_q;
      c8_pkg::S_EX: begin
        nxt  <= ex_next;
        flag <= alu_flag;
        hit  <= 1'b0;
        case (op_hi)
          c8_pkg::OPC_SYS: begin
            if (ir == c8_pkg::OP_CLS) drew <= 1'b1;
            else if (ir != c8_pkg::OP_RET) stat <= c8_pkg::ST_SYS;
          end
          c8_pkg::OPC_DRW: drew <= 1'b1;
          default:         drew <= drew;
        endcase
        if (kind == c8_pkg::K_ILLEGAL) stat <= c8_pkg::ST_HALT;
        else if (kind == c8_pkg::K_NOKEY) stat <= c8_pkg::ST_WAIT;
      end
      c8_pkg::S_DR1: sbyte <= m_q;
      c8_pkg::S_DR2: hit <= hit | (|(f_q & mask));
      c8_pkg::S_DONE: begin
        if (out_free) begin
          result.status          <= stat;
          result.program_counter <= pc;
          result.read_data       <= rdat;
          result.display_changed <= drew;
          result.sound_active    <= (st != 8'd0);
        end
      end
      default: sbyte <= sbyte;
    endcase
  end

endmodule

// ===== rtl/chip8_instruction_core_top.sv =====
// Top level of the CHIP-8 instruction core: controller, datapath and checks.
//
// Usage:
//   The item channel (item_valid / item_stall / item) carries one command:
//   execute one instruction, write a memory byte, read a memory byte, or read
//   one display pixel. The result channel (result_valid / result_stall /
//   result) returns exactly one result per item, in order.
//   After reset the core runs a clearing pass that loads the font, zeroes
//   the rest of memory, the display and V0..VF; item_stall stays high until
//   it is done. Items are handled one at a time. A memory write is done in
//   the command step; a read or pixel read adds a step to capture the data.
//   A plain instruction runs two byte fetches, two register-file reads,
//   execute and commit; a flag-setting register op adds a flag write.
//   Sprite drawing adds a read, capture and write per row plus a collision
//   flag write; store and load a read and a write per register; BCD and
//   screen clear a write per digit or row. A 15-row sprite is longest.
//   The result sits in an output register: the next item is accepted as soon
//   as the result is loaded, even while the receiver holds result_stall.
//   A finished item waits in the core while the output register is still
//   full and stalled, and the item channel stays stalled meanwhile.
module chip8_instruction_core_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  c8_pkg::in_item_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output c8_pkg::out_item_t result
);

  c8_pkg::ctl_t ctl;
  c8_pkg::sts_t sts;

  c8_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .sts        (sts),
    .ctl        (ctl)
  );

  c8_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Take an item only from the idle step.
  assign item_stall = (ctl.step != c8_pkg::S_IDLE);

  // Hold the item channel busy right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item channel not busy after accepting an item");

  // Hold off items when reset has just been released, as the clearing pass begins.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> item_stall)
    else $error("item taken during clearing pass");

  // A new result only appears at the end of work on an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without an item in progress");

endmodule

// ===== tb/sv/tb_chip8_instruction_core_top.sv =====
// Testbench for the CHIP-8 instruction core: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

// Predicts one result per item from a private copy of the core state and
// checks each arriving result against the oldest prediction.
class c8_scoreboard;
  logic [7:0]        mem [4096];
  bit                frame [2048];
  logic [7:0]        v [16];
  logic [11:0]       ireg, pc;
  logic [11:0]       calls [16];
  logic [3:0]        sp;
  logic [7:0]        dly, snd;
  bit                halted;
  c8_pkg::out_item_t expected_q [$];
  int                errors, checked, execs, draws, waits;

  function new();
    foreach (mem[i]) mem[i] = (i < c8_pkg::FONT_LEN) ? c8_pkg::FONT_ROM[i] : 8'h00;
    foreach (frame[i]) frame[i] = 0;
    foreach (v[i]) v[i] = 8'h00;
    foreach (calls[i]) calls[i] = '0;
    ireg = '0; pc = c8_pkg::PROGRAM_START; sp = '0; dly = '0; snd = '0; halted = 0;
  endfunction

  function void report(string what, int got, int want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endfunction

  // Run the instruction at pc; return its status.
  function logic [1:0] run_op(logic [15:0] keys, logic [7:0] rnd, output bit drew);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [11:0] nnn, nxt;
    logic [7:0]  kk, vx, vy, res, row;
    logic [8:0]  sum;
    logic [1:0]  status;
    bit          fl, setf, hit, any, held, skip;
    int          py, pos;
    drew = 0;
    status = c8_pkg::ST_OK;
    op = {mem[pc], mem[pc + 12'd1]};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nnn = op[11:0]; kk = op[7:0];
    vx = v[x]; vy = v[y];
    nxt = pc + 12'd2;
    case (op[15:12])
      c8_pkg::OPC_SYS: begin
        if (op == c8_pkg::OP_CLS) begin
          foreach (frame[i]) frame[i] = 0;
          drew = 1;
        end else if (op == c8_pkg::OP_RET) begin
          sp = sp - 4'd1;
          nxt = calls[sp] + 12'd2;
        end else begin
          status = c8_pkg::ST_SYS;
        end
      end
      c8_pkg::OPC_JP: nxt = nnn;
      c8_pkg::OPC_CALL: begin
        calls[sp] = pc;
        sp = sp + 4'd1;
        nxt = nnn;
      end
      c8_pkg::OPC_SEK:  if (vx == kk) nxt = nxt + 12'd2;
      c8_pkg::OPC_SNEK: if (vx != kk) nxt = nxt + 12'd2;
      c8_pkg::OPC_SER:  if (vx == vy) nxt = nxt + 12'd2;
      c8_pkg::OPC_LDK:  v[x] = kk;
      c8_pkg::OPC_ADDK: v[x] = vx + kk;
      c8_pkg::OPC_ALU: begin
        setf = 1; fl = 0;
        case (n)
          c8_pkg::ALU_MOV: begin res = vy; setf = 0; end
          c8_pkg::ALU_OR:  begin res = vx | vy; setf = 0; end
          c8_pkg::ALU_AND: begin res = vx & vy; setf = 0; end
          c8_pkg::ALU_XOR: begin res = vx ^ vy; setf = 0; end
          c8_pkg::ALU_ADD: begin sum = {1'b0, vx} + vy; res = sum[7:0]; fl = sum[8]; end
          c8_pkg::ALU_SUB: begin res = vx - vy; fl = (vx >= vy); end
          c8_pkg::ALU_SHR: begin res = vx >> 1; fl = vx[0]; end
          c8_pkg::ALU_SBN: begin res = vy - vx; fl = (vy >= vx); end
          c8_pkg::ALU_SHL: begin res = vx << 1; fl = vx[7]; end
          default: begin
            halted = 1;
            return c8_pkg::ST_HALT;
          end
        endcase
        v[x] = res;
        if (setf) v[c8_pkg::FLAG_REG] = {7'd0, fl};
      end
      c8_pkg::OPC_SNER: if (vx != vy) nxt = nxt + 12'd2;
      c8_pkg::OPC_LDI:  ireg = nnn;
      c8_pkg::OPC_JPV0: nxt = nnn + {4'd0, v[0]};
      c8_pkg::OPC_RND:  v[x] = rnd & kk;
      c8_pkg::OPC_DRW: begin
        hit = 0;
        for (int r = 0; r < n; r++) begin
          row = mem[ireg + 12'(r)];
          py = (vy + r) % c8_pkg::ROWS;
          for (int c = 0; c < 8; c++) begin
            if (row[7-c]) begin
              pos = py * c8_pkg::SCREEN_W + ((vx + c) % c8_pkg::SCREEN_W);
              if (frame[pos]) hit = 1;
              frame[pos] = !frame[pos];
            end
          end
        end
        v[c8_pkg::FLAG_REG] = {7'd0, hit};
        drew = 1;
      end
      c8_pkg::OPC_KEY: begin
        held = keys[vx[3:0]];
        skip = (kk == c8_pkg::KEY_DOWN) ? held : !held;
        if (skip) nxt = nxt + 12'd2;
      end
      default: begin
        case (kk)
          c8_pkg::FX_GET_DT: v[x] = dly;
          c8_pkg::FX_WAIT: begin
            any = 0;
            for (int k = 0; k < 16; k++)
              if (keys[k]) begin v[x] = 8'(k); any = 1; end
            if (!any) return c8_pkg::ST_WAIT;
          end
          c8_pkg::FX_SET_DT: dly = vx;
          c8_pkg::FX_SET_ST: snd = vx;
          c8_pkg::FX_ADD_I:  ireg = ireg + {4'd0, vx};
          c8_pkg::FX_FONT:   ireg = {8'd0, vx[3:0]} * 12'd5;
          c8_pkg::FX_BCD: begin
            mem[ireg]         = vx / 8'd100;
            mem[ireg + 12'd1] = (vx / 8'd10) % 8'd10;
            mem[ireg + 12'd2] = vx % 8'd10;
          end
          c8_pkg::FX_STORE: for (int i = 0; i <= x; i++) mem[ireg + 12'(i)] = v[i];
          c8_pkg::FX_LOAD:  for (int i = 0; i <= x; i++) v[i] = mem[ireg + 12'(i)];
          default: begin
            halted = 1;
            return c8_pkg::ST_HALT;
          end
        endcase
      end
    endcase
    pc = nxt;
    if (dly != 0) dly--;
    if (snd != 0) snd--;
    return status;
  endfunction

  // Advance the state for one accepted item and queue its result.
  function void note_item(c8_pkg::in_item_t it);
    c8_pkg::out_item_t e;
    bit                drew;
    e = '0;
    drew = 0;
    e.status = halted ? c8_pkg::ST_HALT : c8_pkg::ST_OK;
    case (it.command)
      c8_pkg::CMD_EXEC: begin
        if (!halted) begin
          e.status = run_op(it.keypad, it.random_byte, drew);
          execs++;
          if (drew) draws++;
          if (e.status == c8_pkg::ST_WAIT) waits++;
        end
      end
      c8_pkg::CMD_WRITE: mem[it.address] = it.write_data;
      c8_pkg::CMD_READ:  e.read_data = mem[it.address];
      default:   e.read_data = {7'd0, frame[it.address % c8_pkg::DISPLAY_PIXELS]};
    endcase
    e.program_counter = pc;
    e.display_changed = drew;
    e.sound_active = (snd != 0);
    expected_q.push_back(e);
  endfunction

  function void check_result(c8_pkg::out_item_t got);
    c8_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result", got, 0);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.program_counter != want.program_counter)
      report("program_counter", got.program_counter, want.program_counter);
    if (got.read_data != want.read_data) report("read_data", got.read_data, want.read_data);
    if (got.display_changed != want.display_changed)
      report("display_changed", got.display_changed, want.display_changed);
    if (got.sound_active != want.sound_active)
      report("sound_active", got.sound_active, want.sound_active);
  endfunction
endclass

module tb_chip8_instruction_core_top;
  logic              clk = 0;
  logic              rst = 1;
  logic              item_valid = 0;
  logic              item_stall;
  c8_pkg::in_item_t  item = '0;
  logic              result_valid;
  logic              result_stall = 0;
  c8_pkg::out_item_t result;

  int send_idle = 11;   // percent of cycles the sender holds valid low
  int recv_idle = 76;   // percent of cycles the receiver stalls

  c8_scoreboard sb = new();

  localparam logic [3:0] ALU_LEGAL [9] = '{c8_pkg::ALU_MOV, c8_pkg::ALU_OR, c8_pkg::ALU_AND,
                                           c8_pkg::ALU_XOR, c8_pkg::ALU_ADD, c8_pkg::ALU_SUB,
                                           c8_pkg::ALU_SHR, c8_pkg::ALU_SBN, c8_pkg::ALU_SHL};
  localparam logic [7:0] FX_LEGAL [9] = '{c8_pkg::FX_GET_DT, c8_pkg::FX_WAIT,
                                          c8_pkg::FX_SET_DT, c8_pkg::FX_SET_ST,
                                          c8_pkg::FX_ADD_I, c8_pkg::FX_FONT, c8_pkg::FX_BCD,
                                          c8_pkg::FX_STORE, c8_pkg::FX_LOAD};

  chip8_instruction_core_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Check each result that crosses the handshake, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= ($urandom_range(99) < recv_idle);
  end

  // Present one item, hold it until accepted, and log it with the predictor.
  // Valid stays high across back-to-back items; drop it only for an idle gap.
  task automatic send(c8_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  function automatic c8_pkg::in_item_t make_item(logic [1:0] cmd, logic [11:0] addr,
                                                 logic [7:0] data, logic [15:0] keys);
    c8_pkg::in_item_t it;
    it.command = cmd;
    it.address = addr;
    it.write_data = data;
    it.keypad = keys;
    it.random_byte = 8'($urandom);
    return it;
  endfunction

  // Place an opcode at the current program counter and execute it.
  task automatic run_op(logic [15:0] op, logic [15:0] keys);
    send(make_item(c8_pkg::CMD_WRITE, sb.pc, op[15:8], 16'($urandom)));
    send(make_item(c8_pkg::CMD_WRITE, sb.pc + 12'd1, op[7:0], 16'($urandom)));
    send(make_item(c8_pkg::CMD_EXEC, 12'($urandom), 8'($urandom), keys));
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_op();
    logic [3:0]  grp;
    logic [11:0] low;
    grp = 4'($urandom);
    low = 12'($urandom);
    case (grp)
      c8_pkg::OPC_SYS: begin
        case ($urandom_range(2))
          0: return c8_pkg::OP_CLS;
          1: return c8_pkg::OP_RET;
          default: return {c8_pkg::OPC_SYS, low};
        endcase
      end
      c8_pkg::OPC_ALU:  return {c8_pkg::OPC_ALU, low[11:4], ALU_LEGAL[$urandom_range(8)]};
      c8_pkg::OPC_KEY:
        return {c8_pkg::OPC_KEY, low[11:8], $urandom_range(1) ? c8_pkg::KEY_DOWN : low[7:0]};
      c8_pkg::OPC_MISC: return {c8_pkg::OPC_MISC, low[11:8], FX_LEGAL[$urandom_range(8)]};
      default:  return {grp, low};
    endcase
  endfunction

  function automatic logic [15:0] random_keys();
    return ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
  endfunction

  // Mostly freshly placed instructions; the rest reads, pixel reads,
  // stray writes and executes of whatever already sits at pc.
  task automatic random_items(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_op(random_op(), random_keys());
      end else if (pick < 78) begin
        send(make_item(c8_pkg::CMD_EXEC, 12'($urandom), 8'($urandom), random_keys()));
      end else if (pick < 88) begin
        send(make_item(c8_pkg::CMD_READ, 12'($urandom), 8'($urandom), random_keys()));
      end else if (pick < 95) begin
        send(make_item(c8_pkg::CMD_PIXEL, 12'($urandom), 8'($urandom), random_keys()));
      end else begin
        send(make_item(c8_pkg::CMD_WRITE, 12'($urandom), 8'($urandom), random_keys()));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: extremes of registers and fields, flags, wraps, stack, keys.
    run_op(16'h60FF, 16'h0000);                 // V0 = FF
    run_op(16'h61FF, 16'h0000);                 // V1 = FF
    run_op(16'h8014, 16'h0000);                 // add with carry out
    run_op(16'h62FE, 16'h0000);
    run_op(16'h8225, 16'h0000);                 // subtract of equal values sets flag
    run_op(16'h8F16, 16'h0000);                 // shift into VF, flag survives
    run_op(16'h811E, 16'h0000);
    run_op(16'h00E0, 16'h0000);                 // clear screen
    run_op(16'h633E, 16'h0000);                 // V3 = 62
    run_op(16'h641E, 16'h0000);                 // V4 = 30
    run_op(16'hF029, 16'h0000);                 // font of low nibble of FE
    run_op(16'hD345, 16'h0000);                 // draw wrapping both edges
    run_op(16'hD34F, 16'h0000);                 // redraw: collision
    send(make_item(c8_pkg::CMD_PIXEL, 12'hFFF, 8'h00, 16'h0000));
    send(make_item(c8_pkg::CMD_PIXEL, 12'(30 * 64 + 62), 8'hFF, 16'hFFFF));
    run_op(16'hA000 | 16'hFFE, 16'h0000);       // I near top of memory
    run_op(16'hF033, 16'h0000);                 // BCD of 254 wraps memory
    run_op(16'hFF55, 16'h0000);
    run_op(16'hFF65, 16'h0000);
    run_op(16'hF50A, 16'h0000);                 // no key held: wait
    run_op(16'hF50A, 16'h8001);                 // highest key wins
    run_op(16'hE59E, 16'h8000);
    run_op(16'hE5A1, 16'h8000);
    run_op(16'hF018, 16'h0000);                 // sound timer on
    run_op(16'h2FFE, 16'h0000);                 // call at the top of memory
    run_op(16'h00EE, 16'h0000);
    run_op(16'h0123, 16'h0000);                 // unsupported system call
    run_op(16'hBFFF, 16'h0000);                 // jump wraps
    send(make_item(c8_pkg::CMD_READ, 12'hFFF, 8'h00, 16'h0000));

    random_items(42);
    drain();

    send_idle = 76;
    recv_idle = 11;
    random_items(42);
    drain();

    send_idle = 0;
    recv_idle = 0;
    random_items(42);

    // Halt on an illegal opcode, then make sure everything reports halted.
    run_op($urandom_range(1) ? 16'h8128 : 16'hF1FF, 16'h0000);
    repeat (4) begin
      send(make_item(c8_pkg::CMD_EXEC, 12'($urandom), 8'($urandom), 16'($urandom)));
      send(make_item(c8_pkg::CMD_READ, 12'($urandom), 8'($urandom), 16'($urandom)));
      send(make_item(c8_pkg::CMD_PIXEL, 12'($urandom), 8'($urandom), 16'($urandom)));
    end
    drain();
    repeat (80) @(posedge clk);

    $display("Checked %0d results: %0d instructions run, %0d draws or clears, %0d key waits.",
             sb.checked, sb.execs, sb.draws, sb.waits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_chip8_instruction_core_top: PASS");
    end else begin
      $display("tb_chip8_instruction_core_top: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("tb_chip8_instruction_core_top: FAIL");
    $finish;
  end
endmodule

// ===== chip8_instruction_core_top.f =====
rtl/c8_pkg.sv
rtl/c8_ram.sv
rtl/c8_ctrl.sv
rtl/c8_datapath.sv
rtl/chip8_instruction_core_top.sv
tb/sv/tb_chip8_instruction_core_top.sv
